/* src/gdc_pkg.sv */
// shared types, constants and calendar helpers for the gregorian date counter
`default_nettype none
package gdc_pkg;

    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 14;
    localparam int STEP_W     = 10;
    localparam int COUNT_BITS = 10;
    localparam int CENT_W     = 8;
    localparam int PROD_W     = 27;
    localparam int RECIP_SHIFT = 19;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LONG   = 5'd31;
    localparam logic [DAY_W-1:0]   DAY_SHORT  = 5'd30;
    localparam logic [DAY_W-1:0]   DAY_FEB_LY = 5'd29;
    localparam logic [DAY_W-1:0]   DAY_FEB    = 5'd28;
    localparam logic [DAY_W-1:0]   DAY_NONE   = 5'd0;
    localparam logic [YEAR_W-1:0]  YEAR_RESET = 14'd2000;
    // floor(2^19 / 100) + 1, exact quotient for every 14-bit year
    localparam logic [12:0]        RECIP_100  = 13'd5243;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_BACK    = 2'd2,
        OP_COMPARE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ORD_EARLIER = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_LATER   = 2'd2
    } order_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_EXEC,
        ST_STEP,
        ST_SETTLE,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic cnt_zero;
        logic at_bound;
    } dp_stat_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_LONG;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_SHORT;
            MONTH_FEB:                                  len = leap ? DAY_FEB_LY : DAY_FEB;
            default:                                    len = DAY_NONE;
        endcase
        return len;
    endfunction

    // year / 100 by reciprocal multiply
    function automatic logic [CENT_W-1:0] century_of(input logic [YEAR_W-1:0] year);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(year) * PROD_W'(RECIP_100);
        return prod[RECIP_SHIFT +: CENT_W];
    endfunction

    // 4/100/400 rule given the year and its century quotient
    function automatic logic leap_of(input logic [YEAR_W-1:0] year,
                                     input logic [CENT_W-1:0] cent);
        logic [YEAR_W:0] hundred;
        logic            on_century;
        hundred    = (YEAR_W+1)'({cent, 6'b0}) + (YEAR_W+1)'({cent, 5'b0})
                   + (YEAR_W+1)'({cent, 2'b0});
        on_century = (hundred == {1'b0, year});
        return (year[1:0] == 2'b00) && !(on_century && (cent[1:0] != 2'b00));
    endfunction

endpackage
`default_nettype wire

/* src/gregorian_date_counter.sv */
// top level of the gregorian date counter: sequencer plus datapath
//
//  channel   handshake         fields
//  request   start / busy      op, day_in, month_in, year_in, step_count
//  result    done (1 cycle)    day_out, month_out, year_out, load_ok, order,
//                              leap, days_in_month
//
// a transaction is taken at a clock edge with start high and busy low
// load and compare: done follows the prep, execute and settle states after that edge
// advance and go back: prep, execute, then one day per cycle in the stepping loop,
// then settle and done; days actually stepped are at most step_count
// done lasts one cycle and cannot be held off; busy drops in the next cycle
// reset puts the date at 2000-01-01 with no warm-up sweep
`default_nettype none
module gregorian_date_counter (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire [1:0]                    op,
    input  wire [gdc_pkg::DAY_W-1:0]     day_in,
    input  wire [gdc_pkg::MONTH_W-1:0]   month_in,
    input  wire [gdc_pkg::YEAR_W-1:0]    year_in,
    input  wire [gdc_pkg::STEP_W-1:0]    step_count,
    output logic                         done,
    output logic [gdc_pkg::DAY_W-1:0]    day_out,
    output logic [gdc_pkg::MONTH_W-1:0]  month_out,
    output logic [gdc_pkg::YEAR_W-1:0]   year_out,
    output logic                         load_ok,
    output logic [1:0]                   order,
    output logic                         leap,
    output logic [gdc_pkg::DAY_W-1:0]    days_in_month
);
    import gdc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    gdc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    gdc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .op            (op),
        .day_in        (day_in),
        .month_in      (month_in),
        .year_in       (year_in),
        .step_count    (step_count),
        .day_out       (day_out),
        .month_out     (month_out),
        .year_out      (year_out),
        .load_ok       (load_ok),
        .order         (order),
        .leap          (leap),
        .days_in_month (days_in_month)
    );

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a transaction");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted transaction did not raise busy");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!load_ok || order == ORD_EARLIER))
        else $error("load and compare flags set together");

    a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (day_out >= DAY_FIRST && day_out <= days_in_month
                  && days_in_month >= DAY_FEB))
        else $error("stored date outside its month");

endmodule
`default_nettype wire

/* src/gdc_leap.sv */
// leap year flag with one register stage after the century multiply
`default_nettype none
module gdc_leap (
    input  wire                        clk,
    input  wire [gdc_pkg::YEAR_W-1:0]  year,
    output logic                       leap
);
    import gdc_pkg::*;

    logic [CENT_W-1:0] cent_reg;
    logic [YEAR_W-1:0] year_reg;

    always_ff @(posedge clk)
    begin
        cent_reg <= century_of(year);
        year_reg <= year;
    end

    assign leap = leap_of(year_reg, cent_reg);

endmodule
`default_nettype wire

/* src/gdc_ctrl.sv */
// sequencer: capture, execute, day stepping and result strobe
`default_nettype none
module gdc_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    output logic                done,
    output gdc_pkg::dp_cmd_t    cmd,
    input  gdc_pkg::dp_stat_t   stat
);
    import gdc_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.step    = 1'b0;
        busy        = 1'b1;
        done        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            // leap flag of the requested year settles here
            ST_PREP:
                state_next = ST_EXEC;
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.op == OP_ADVANCE || stat.op == OP_BACK)
                    state_next = ST_STEP;
                else
                    state_next = ST_SETTLE;
            end
            ST_STEP:
            begin
                if (stat.cnt_zero || stat.at_bound)
                    state_next = ST_SETTLE;
                else
                    cmd.step = 1'b1;
            end
            // leap flag of the new stored year settles here
            ST_SETTLE:
                state_next = ST_DONE;
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* src/gdc_datapath.sv */
// date registers, request registers, day step logic, load check and compare
`default_nettype none
module gdc_datapath (
    input  wire                          clk,
    input  wire                          rst_n,
    input  gdc_pkg::dp_cmd_t             cmd,
    output gdc_pkg::dp_stat_t            stat,
    input  wire [1:0]                    op,
    input  wire [gdc_pkg::DAY_W-1:0]     day_in,
    input  wire [gdc_pkg::MONTH_W-1:0]   month_in,
    input  wire [gdc_pkg::YEAR_W-1:0]    year_in,
    input  wire [gdc_pkg::STEP_W-1:0]    step_count,
    output logic [gdc_pkg::DAY_W-1:0]    day_out,
    output logic [gdc_pkg::MONTH_W-1:0]  month_out,
    output logic [gdc_pkg::YEAR_W-1:0]   year_out,
    output logic                         load_ok,
    output logic [1:0]                   order,
    output logic                         leap,
    output logic [gdc_pkg::DAY_W-1:0]    days_in_month
);
    import gdc_pkg::*;

    logic [DAY_W-1:0]      day_reg, day_next;
    logic [MONTH_W-1:0]    month_reg, month_next;
    logic [YEAR_W-1:0]     year_reg, year_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  load_ok_reg, load_ok_next;
    order_t                order_reg, order_next;

    op_t                   req_op_reg;
    logic [DAY_W-1:0]      req_day_reg;
    logic [MONTH_W-1:0]    req_month_reg;
    logic [YEAR_W-1:0]     req_year_reg;

    logic                  cur_leap;
    logic                  req_leap;
    logic [DAY_W-1:0]      cur_len;
    logic [DAY_W-1:0]      prev_len;
    logic                  load_valid;
    logic                  at_max;
    logic                  at_min;
    order_t                cmp;

    gdc_leap u_cur_leap (
        .clk  (clk),
        .year (year_reg),
        .leap (cur_leap)
    );

    gdc_leap u_req_leap (
        .clk  (clk),
        .year (req_year_reg),
        .leap (req_leap)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_op_reg    <= op_t'(op);
            req_day_reg   <= day_in;
            req_month_reg <= month_in;
            req_year_reg  <= year_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg     <= DAY_FIRST;
            month_reg   <= MONTH_JAN;
            year_reg    <= YEAR_RESET;
            cnt_reg     <= '0;
            load_ok_reg <= 1'b0;
            order_reg   <= ORD_EARLIER;
        end
        else
        begin
            day_reg     <= day_next;
            month_reg   <= month_next;
            year_reg    <= year_next;
            cnt_reg     <= cnt_next;
            load_ok_reg <= load_ok_next;
            order_reg   <= order_next;
        end
    end

    assign cur_len  = month_len(month_reg, cur_leap);
    assign prev_len = month_len(month_reg - 4'd1, cur_leap);
    assign at_max   = (year_reg >= YEAR_MAX) && (month_reg == MONTH_DEC)
                   && (day_reg == DAY_LONG);
    assign at_min   = (year_reg <= YEAR_MIN) && (month_reg == MONTH_JAN)
                   && (day_reg == DAY_FIRST);

    assign load_valid = (req_year_reg >= YEAR_MIN) && (req_year_reg <= YEAR_MAX)
                     && (req_month_reg >= MONTH_JAN) && (req_month_reg <= MONTH_DEC)
                     && (req_day_reg >= DAY_FIRST)
                     && (req_day_reg <= month_len(req_month_reg, req_leap));

    // year, then month, then day on the raw request fields
    always_comb
    begin
        priority if (year_reg != req_year_reg)
            cmp = (year_reg < req_year_reg) ? ORD_EARLIER : ORD_LATER;
        else if (month_reg != req_month_reg)
            cmp = (month_reg < req_month_reg) ? ORD_EARLIER : ORD_LATER;
        else if (day_reg != req_day_reg)
            cmp = (day_reg < req_day_reg) ? ORD_EARLIER : ORD_LATER;
        else
            cmp = ORD_EQUAL;
    end

    always_comb
    begin
        day_next     = day_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        cnt_next     = cnt_reg;
        load_ok_next = load_ok_reg;
        order_next   = order_reg;
        if (cmd.capture)
            cnt_next = COUNT_BITS'(step_count);
        if (cmd.exec)
        begin
            load_ok_next = 1'b0;
            order_next   = ORD_EARLIER;
            if (req_op_reg == OP_LOAD && load_valid)
            begin
                day_next     = req_day_reg;
                month_next   = req_month_reg;
                year_next    = req_year_reg;
                load_ok_next = 1'b1;
            end
            if (req_op_reg == OP_COMPARE)
                order_next = cmp;
        end
        if (cmd.step)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (req_op_reg == OP_ADVANCE)
            begin
                if (day_reg >= cur_len)
                begin
                    day_next = DAY_FIRST;
                    if (month_reg >= MONTH_DEC)
                    begin
                        month_next = MONTH_JAN;
                        year_next  = year_reg + 1'b1;
                    end
                    else
                        month_next = month_reg + 1'b1;
                end
                else
                    day_next = day_reg + 1'b1;
            end
            else
            begin
                if (day_reg <= DAY_FIRST)
                begin
                    if (month_reg <= MONTH_JAN)
                    begin
                        year_next  = year_reg - 1'b1;
                        month_next = MONTH_DEC;
                        day_next   = DAY_LONG;
                    end
                    else
                    begin
                        month_next = month_reg - 1'b1;
                        day_next   = prev_len;
                    end
                end
                else
                    day_next = day_reg - 1'b1;
            end
        end
    end

    assign stat.op       = req_op_reg;
    assign stat.cnt_zero = (cnt_reg == '0);
    assign stat.at_bound = (req_op_reg == OP_ADVANCE) ? at_max : at_min;

    assign day_out       = day_reg;
    assign month_out     = month_reg;
    assign year_out      = year_reg;
    assign load_ok       = load_ok_reg;
    assign order         = order_reg;
    assign leap          = cur_leap;
    assign days_in_month = cur_len;

endmodule
`default_nettype wire
